// ----- sv/per_channel_scale_bias_fp16_macros.svh -----
// Assertion macros shared by the per-channel scale and bias block.
`ifndef PER_CHANNEL_SCALE_BIAS_FP16_MACROS_SVH
`define PER_CHANNEL_SCALE_BIAS_FP16_MACROS_SVH
`ifndef ASSERT_OFF
`define PCSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PCSB_NEVER(lbl, cond, msg) `PCSB_ASSERT(lbl, !(cond), msg)
`else
`define PCSB_ASSERT(lbl, prop, msg)
`define PCSB_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/pcsb_pkg.sv -----
// Types and constants of the per-channel scale and bias block.
`default_nettype none
package pcsb_pkg;
    localparam int MAX_CHANNELS = 1024;
    localparam int BLOCK_LANES  = 8;
    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int LANE_W = $clog2(BLOCK_LANES);
    localparam int CNT_W  = CH_W + 1;
    localparam int POS_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [15:0] FP16_ONE  = 16'h3C00;
    localparam logic [15:0] FP16_ZERO = 16'h0000;
    localparam logic [15:0] FP16_QNAN = 16'h7E00;
    localparam logic [15:0] FP16_INF  = 16'h7C00;

    localparam logic [1:0] LAYOUT_PLANAR      = 2'd0;
    localparam logic [1:0] LAYOUT_INTERLEAVED = 2'd1;
    localparam logic [1:0] LAYOUT_BLOCKED     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BETA  = 3'd4;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  coef_index;
        logic [15:0] alpha_value;
        logic [15:0] beta_value;
        logic [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [15:0] result;
        logic [9:0]  channel;
    } t_out_word;

    typedef struct packed {
        logic [15:0]     alpha;
        logic [15:0]     beta;
        logic [15:0]     x;
        logic [CH_W-1:0] ch;
    } t_fma_job;

    typedef struct packed {
        logic     valid;
        t_fma_job job;
    } t_job_push;
endpackage
`default_nettype wire

// ----- sv/pcsb_front.sv -----
// Front end: configuration, channel walk, coefficient table and job issue.
`default_nettype none
module pcsb_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  pcsb_pkg::t_in_word           i_item,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [pcsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [pcsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire [pcsb_pkg::QCNT_W-1:0]   i_q_count,
    output pcsb_pkg::t_job_push          o_push
);
    import pcsb_pkg::*;

    logic [1:0]       r_layout;
    logic [CNT_W-1:0] r_chan_cnt;
    logic [POS_W-1:0] r_plane;
    logic             r_use_alpha, r_use_beta;
    logic [CH_W-1:0]  r_chan;
    logic [POS_W-1:0] r_pos;
    logic [LANE_W-1:0] r_lane;
    logic [CH_W-1:0]  n_chan;
    logic [POS_W-1:0] n_pos;
    logic [LANE_W-1:0] n_lane;

    logic [31:0]      r_coef [0:MAX_CHANNELS-1];
    logic [31:0]      r_rd;
    logic             r_fvld;
    logic [15:0]      r_x;
    logic [CH_W-1:0]  r_ch;

    logic             acc, acc_load, acc_data, cfg_wr;
    logic [CNT_W-1:0] cc, blocks;
    logic [POS_W-1:0] ps;
    logic [1:0]       mode;
    logic [CH_W-1:0]  ch;
    logic             pos_last, chan_last, lane_last;
    logic [QCNT_W:0]  used;

    // Reserve a queue slot for the word held in the table read stage
    assign used  = {1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_fvld};
    assign full  = used >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign acc   = push && !full;
    assign acc_load = acc && (i_item.cmd == CMD_LOAD);
    assign acc_data = acc && (i_item.cmd == CMD_SAMPLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    // Clamp the configured sizes, resolve the layout and count the blocks
    always_comb begin
        if (r_chan_cnt == '0) begin
            cc = CNT_W'(1);
        end else if (r_chan_cnt > CNT_W'(MAX_CHANNELS)) begin
            cc = CNT_W'(MAX_CHANNELS);
        end else begin
            cc = r_chan_cnt;
        end
        ps = (r_plane == '0) ? POS_W'(1) : r_plane;
        mode = (cc == CNT_W'(1) || r_layout == 2'd3) ? LAYOUT_PLANAR : r_layout;
        blocks = (cc + CNT_W'(BLOCK_LANES - 1)) >> LANE_W;
    end

    // Walk the channel counters
    always_comb begin
        n_chan = r_chan;
        n_pos = r_pos;
        n_lane = r_lane;
        pos_last = (r_pos == ps - POS_W'(1));
        lane_last = (r_lane == LANE_W'(BLOCK_LANES - 1));
        chan_last = 1'b0;
        ch = r_chan;
        case (mode)
            LAYOUT_BLOCKED: begin
                ch = {r_chan[CH_W-LANE_W-1:0], r_lane};
                chan_last = ({1'b0, r_chan} == blocks - CNT_W'(1));
                n_lane = r_lane + LANE_W'(1);
                if (lane_last) begin
                    n_pos = pos_last ? '0 : r_pos + POS_W'(1);
                    if (pos_last) begin
                        n_chan = chan_last ? '0 : r_chan + CH_W'(1);
                    end
                end
            end
            LAYOUT_INTERLEAVED: begin
                chan_last = ({1'b0, r_chan} == cc - CNT_W'(1));
                n_chan = chan_last ? '0 : r_chan + CH_W'(1);
                if (chan_last) begin
                    n_pos = pos_last ? '0 : r_pos + POS_W'(1);
                end
            end
            default: begin
                chan_last = ({1'b0, r_chan} == cc - CNT_W'(1));
                n_pos = pos_last ? '0 : r_pos + POS_W'(1);
                if (pos_last) begin
                    n_chan = chan_last ? '0 : r_chan + CH_W'(1);
                end
            end
        endcase
    end

    // Hold configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_PLANAR;
            r_chan_cnt <= CNT_W'(1);
            r_plane <= POS_W'(1);
            r_use_alpha <= 1'b1;
            r_use_beta <= 1'b1;
            r_chan <= '0;
            r_pos <= '0;
            r_lane <= '0;
            r_fvld <= 1'b0;
        end else begin
            r_fvld <= acc_data;
            if (acc_data) begin
                r_chan <= n_chan;
                r_pos <= n_pos;
                r_lane <= n_lane;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_LAYOUT:    r_layout <= i_cfg_data[1:0];
                    CFG_CHANNELS:  r_chan_cnt <= i_cfg_data[CNT_W-1:0];
                    CFG_PLANE:     r_plane <= i_cfg_data[POS_W-1:0];
                    CFG_USE_ALPHA: r_use_alpha <= i_cfg_data[0];
                    CFG_USE_BETA:  r_use_beta <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index <= CFG_USE_BETA) begin
                    r_chan <= '0;
                    r_pos <= '0;
                    r_lane <= '0;
                end
            end
        end
    end

    // Write or read the coefficient table
    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_coef[i_item.coef_index[CH_W-1:0]] <= {i_item.alpha_value, i_item.beta_value};
        end
        if (acc_data) begin
            r_rd <= r_coef[ch];
            r_x <= i_item.sample;
            r_ch <= ch;
        end
    end

    // Issue the job with defaults applied
    always_comb begin
        o_push.valid = r_fvld;
        o_push.job.alpha = r_use_alpha ? r_rd[31:16] : FP16_ONE;
        o_push.job.beta = r_use_beta ? r_rd[15:0] : FP16_ZERO;
        o_push.job.x = r_x;
        o_push.job.ch = r_ch;
    end
endmodule
`default_nettype wire

// ----- sv/pcsb_queue.sv -----
// Short job queue between the front end and the arithmetic pipeline.
`default_nettype none
module pcsb_queue (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  pcsb_pkg::t_job_push         i_push,
    input  wire                         i_pop,
    output logic                        o_vld,
    output pcsb_pkg::t_fma_job          o_job,
    output logic [pcsb_pkg::QCNT_W-1:0] o_count
);
    import pcsb_pkg::*;

    t_fma_job          r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_vld = (r_count != '0);
    assign o_job = r_mem[r_head];
    assign o_count = r_count;
    assign do_pop = i_pop && o_vld;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_tail <= r_tail + QPTR_W'(1);
            end
            if (do_pop) begin
                r_head <= r_head + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(do_pop);
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_tail] <= i_push.job;
        end
    end
endmodule
`default_nettype wire

// ----- sv/pcsb_back.sv -----
// Back end: six-stage binary16 fused multiply-add with one rounding.
`default_nettype none
`include "per_channel_scale_bias_fp16_macros.svh"
module pcsb_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_vld,
    input  pcsb_pkg::t_fma_job  i_job,
    output logic                o_pop,
    output logic                empty,
    input  wire                 pop,
    output pcsb_pkg::t_out_word o_word
);
    import pcsb_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            spec;
        logic [15:0]     specv;
    } t_side;

    logic [6:1] r_vld;
    t_side      r_side [1:6];
    logic       en;

    // Stage 1 and 2 registers
    logic [21:0] r_p1;
    logic [5:0]  r_esum1, r_bsh1;
    logic [10:0] r_mb1;
    logic        r_sp1, r_sb1;
    logic [63:0] r_p2, r_bb2;
    logic        r_sp2, r_sb2;
    // Stage 3 to 6 registers
    logic [63:0] r_mag3, r_mag4, r_mag5;
    logic        r_sg3, r_sg4, r_sg5;
    logic [15:0] r_zv3, r_zv4, r_zv5;
    logic [7:0]  r_nz4;
    logic [2:0]  r_hi4 [0:7];
    logic [5:0]  r_s5;
    logic        r_zero5;
    logic [15:0] r_res6;

    assign en = !r_vld[6] || pop;
    assign o_pop = en && i_vld;
    assign empty = !r_vld[6];
    assign o_word.result = r_res6;
    assign o_word.channel = r_side[6].ch;

    // Stage 1: classify operands and multiply mantissas
    logic        a_nan, x_nan, b_nan, a_inf, x_inf, b_inf, sp;
    logic [4:0]  ea, ex, eb;
    logic [10:0] ma, mx, mb;
    t_side       s1;
    always_comb begin
        ea = i_job.alpha[14:10];
        ex = i_job.x[14:10];
        eb = i_job.beta[14:10];
        sp = i_job.alpha[15] ^ i_job.x[15];
        a_nan = (ea == 5'h1F) && (i_job.alpha[9:0] != '0);
        x_nan = (ex == 5'h1F) && (i_job.x[9:0] != '0);
        b_nan = (eb == 5'h1F) && (i_job.beta[9:0] != '0);
        a_inf = (i_job.alpha[14:0] == FP16_INF[14:0]);
        x_inf = (i_job.x[14:0] == FP16_INF[14:0]);
        b_inf = (i_job.beta[14:0] == FP16_INF[14:0]);
        ma = {(ea != '0), i_job.alpha[9:0]};
        mx = {(ex != '0), i_job.x[9:0]};
        mb = {(eb != '0), i_job.beta[9:0]};
        s1.ch = i_job.ch;
        s1.spec = 1'b1;
        s1.specv = FP16_QNAN;
        if (a_nan || x_nan || b_nan) begin
            s1.specv = FP16_QNAN;
        end else if (a_inf || x_inf) begin
            if (i_job.alpha[14:0] == '0 || i_job.x[14:0] == '0) begin
                s1.specv = FP16_QNAN;
            end else if (b_inf && (i_job.beta[15] != sp)) begin
                s1.specv = FP16_QNAN;
            end else begin
                s1.specv = {sp, FP16_INF[14:0]};
            end
        end else if (b_inf) begin
            s1.specv = i_job.beta;
        end else begin
            s1.spec = 1'b0;
        end
    end

    // Stage 2: align product and addend to units of 2^-27
    logic [63:0] p_al, p_ext, lost_mask;
    logic [5:0]  rsh;
    always_comb begin
        p_ext = {42'd0, r_p1};
        rsh = 6'd23 - r_esum1;
        lost_mask = (64'd1 << rsh) - 64'd1;
        if (r_esum1 >= 6'd23) begin
            p_al = p_ext << (r_esum1 - 6'd23);
        end else begin
            p_al = (p_ext >> rsh) | {63'd0, ((p_ext & lost_mask) != '0)};
        end
    end

    // Stage 3: signed add of aligned magnitudes
    logic [63:0] mag;
    logic        sg;
    always_comb begin
        if (r_sp2 == r_sb2) begin
            mag = r_p2 + r_bb2;
            sg = r_sp2;
        end else if (r_p2 >= r_bb2) begin
            mag = r_p2 - r_bb2;
            sg = r_sp2;
        end else begin
            mag = r_bb2 - r_p2;
            sg = r_sb2;
        end
    end

    // Stage 4: leading one within each byte
    logic [7:0] nz;
    logic [2:0] hi [0:7];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            nz[k] = (r_mag3[8*k +: 8] != '0);
            hi[k] = '0;
            for (int j = 0; j < 8; j++) begin
                if (r_mag3[8*k+j]) begin
                    hi[k] = 3'(j);
                end
            end
        end
    end

    // Stage 5: pick top byte, set the rounding position
    logic [5:0] h, s;
    always_comb begin
        h = '0;
        for (int k = 0; k < 8; k++) begin
            if (r_nz4[k]) begin
                h = {3'(k), r_hi4[k]};
            end
        end
        s = (h >= 6'd13) ? h - 6'd10 : 6'd3;
    end

    // Stage 6: round to nearest even and pack
    logic [63:0] shd, stk_mask;
    logic [10:0] q;
    logic        rnd, stk, inc;
    logic [5:0]  e;
    logic [16:0] bits;
    logic [15:0] res;
    always_comb begin
        shd = r_mag5 >> (r_s5 - 6'd1);
        q = shd[11:1];
        rnd = shd[0];
        stk_mask = (64'd1 << (r_s5 - 6'd1)) - 64'd1;
        stk = ((r_mag5 & stk_mask) != '0);
        inc = rnd && (stk || q[0]);
        e = r_s5 - 6'd3;
        bits = {1'b0, e, 10'd0} + {6'd0, q} + {16'd0, inc};
        if (e > 6'd40 || bits >= {1'b0, FP16_INF}) begin
            bits = {1'b0, FP16_INF};
        end
        if (r_side[5].spec) begin
            res = r_side[5].specv;
        end else if (r_zero5) begin
            res = r_zv5;
        end else begin
            res = {r_sg5, bits[14:0]};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[5:1], i_vld};
        end
    end

    // Advance payload through the stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= s1;
            for (int k = 2; k <= 6; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_p1 <= ma * mx;
            r_esum1 <= 6'({1'b0, (ea != '0) ? ea : 5'd1}) + 6'({1'b0, (ex != '0) ? ex : 5'd1});
            r_bsh1 <= (eb != '0) ? 6'({1'b0, eb}) + 6'd2 : 6'd3;
            r_mb1 <= mb;
            r_sp1 <= sp;
            r_sb1 <= i_job.beta[15];
            r_p2 <= p_al;
            r_bb2 <= {53'd0, r_mb1} << r_bsh1;
            r_sp2 <= r_sp1;
            r_sb2 <= r_sb1;
            r_mag3 <= mag;
            r_sg3 <= sg;
            r_zv3 <= (r_p2 == '0 && r_bb2 == '0) ? {r_sp2 & r_sb2, 15'd0} : FP16_ZERO;
            r_mag4 <= r_mag3;
            r_sg4 <= r_sg3;
            r_zv4 <= r_zv3;
            r_nz4 <= nz;
            r_hi4 <= hi;
            r_mag5 <= r_mag4;
            r_sg5 <= r_sg4;
            r_zv5 <= r_zv4;
            r_s5 <= s;
            r_zero5 <= (r_nz4 == '0);
            r_res6 <= res;
        end
    end

    `PCSB_NEVER(a_pop_empty_queue, o_pop && !i_vld, "popped an empty job queue")
    `PCSB_ASSERT(a_hold_on_stall, r_vld[6] && !pop |=> r_vld[6] && $stable(r_res6), "result lost under stall")
    `PCSB_NEVER(a_nan_quiet, r_vld[6] && (r_res6[14:10] == 5'h1F) && (r_res6[9:0] != '0) && (r_res6 != FP16_QNAN), "non-canonical NaN produced")
endmodule
`default_nettype wire

// ----- sv/per_channel_scale_bias_fp16.sv -----
// Top level of the per-channel binary16 scale and bias block.
// Each sample word becomes alpha[c]*x+beta[c] rounded once to binary16, with c walked by
// counters under the configured layout; load words fill the 1024-entry coefficient table.
// The block takes one word per cycle while full is low: the single-port coefficient table
// serves one load or one lookup per cycle, and the six-stage multiply-add pipeline
// accepts a job every cycle unless the result side stalls.
// A four-entry job queue absorbs result-side stalls before full rises.
// Configuration writes are always ready; mapped ones restart the channel counters.
`default_nettype none
module per_channel_scale_bias_fp16 (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            push,
    output logic                           full,
    input  pcsb_pkg::t_in_word             i_item,
    output logic                           empty,
    input  wire                            pop,
    output pcsb_pkg::t_out_word            o_word,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [pcsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [pcsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcsb_pkg::*;

    t_job_push         qpush;
    t_fma_job          qjob;
    logic              qvld, qpop;
    logic [QCNT_W-1:0] qcount;

    pcsb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_q_count(qcount), .o_push(qpush)
    );

    pcsb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(qpush), .i_pop(qpop),
        .o_vld(qvld), .o_job(qjob), .o_count(qcount)
    );

    pcsb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(qvld), .i_job(qjob), .o_pop(qpop),
        .empty(empty), .pop(pop), .o_word(o_word)
    );
endmodule
`default_nettype wire

// ----- test/per_channel_scale_bias_fp16_tb.sv -----
// Self-checking testbench of the per-channel binary16 scale and bias block.
`timescale 1ns / 100ps
`default_nettype none
module per_channel_scale_bias_fp16_tb;
    import pcsb_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 14;
    localparam int PHASE_WORDS = 104;

    // Scoreboard: shadow tables, registers and counters plus pending results
    class affine_scoreboard;
        logic [15:0] alpha_mem [MAX_CHANNELS];
        logic [15:0] beta_mem [MAX_CHANNELS];
        bit loaded [MAX_CHANNELS];
        logic [1:0] layout;
        logic [10:0] nch;
        logic [23:0] plane;
        bit use_a, use_b;
        int unsigned ch_cnt, pos_cnt, lane_cnt;
        t_out_word pending_q[$];
        int errors;

        function new();
            layout = LAYOUT_PLANAR;
            nch = 1;
            plane = 1;
            use_a = 1;
            use_b = 1;
            ch_cnt = 0;
            pos_cnt = 0;
            lane_cnt = 0;
            errors = 0;
            foreach (loaded[i]) loaded[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LAYOUT:    layout = data[1:0];
                CFG_CHANNELS:  nch = data[10:0];
                CFG_PLANE:     plane = data[23:0];
                CFG_USE_ALPHA: use_a = data[0];
                CFG_USE_BETA:  use_b = data[0];
                default: return;
            endcase
            ch_cnt = 0;
            pos_cnt = 0;
            lane_cnt = 0;
        endfunction

        // Return the channel of the next sample; advance the counters when asked
        function int unsigned walk(bit advance);
            int unsigned cc, ps, blocks, ch, c, p, l;
            logic [1:0] mode;
            cc = (nch == 0) ? 1 : nch;
            if (cc > MAX_CHANNELS) cc = MAX_CHANNELS;
            ps = (plane == 0) ? 1 : plane;
            mode = layout;
            if (cc == 1 || mode == 2'd3) mode = LAYOUT_PLANAR;
            c = ch_cnt;
            p = pos_cnt;
            l = lane_cnt;
            if (mode == LAYOUT_BLOCKED) begin
                blocks = (cc + BLOCK_LANES - 1) / BLOCK_LANES;
                ch = c * BLOCK_LANES + l;
                if (++l >= BLOCK_LANES) begin
                    l = 0;
                    if (++p >= ps) begin
                        p = 0;
                        if (++c >= blocks) c = 0;
                    end
                end
            end else if (mode == LAYOUT_INTERLEAVED) begin
                ch = c;
                if (++c >= cc) begin
                    c = 0;
                    if (++p >= ps) p = 0;
                end
            end else begin
                ch = c;
                if (++p >= ps) begin
                    p = 0;
                    if (++c >= cc) c = 0;
                end
            end
            if (advance) begin
                ch_cnt = c;
                pos_cnt = p;
                lane_cnt = l;
            end
            return ch % MAX_CHANNELS;
        endfunction

        // True when the next sample reads only loaded coefficients
        function bit next_ready(output int unsigned ch);
            ch = walk(0);
            return loaded[ch] || (!use_a && !use_b);
        endfunction

        function void note_word(t_in_word w);
            int unsigned ch;
            t_out_word r;
            if (w.cmd == CMD_LOAD) begin
                alpha_mem[w.coef_index] = w.alpha_value;
                beta_mem[w.coef_index] = w.beta_value;
                loaded[w.coef_index] = 1;
                return;
            end
            ch = walk(1);
            r.channel = ch[9:0];
            r.result = fp16_fma(use_a ? alpha_mem[ch] : FP16_ONE, w.sample,
                                use_b ? beta_mem[ch] : FP16_ZERO);
            pending_q.push_back(r);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %h, got %h", want.result, got.result);
                errors++;
            end
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                errors++;
            end
        endfunction
    endclass

    // Unpack a binary16 value into an integer significand and exponent
    function automatic void fp16_split(input logic [15:0] h, output longint unsigned m,
                                       output int e);
        m = (h[14:10] != 0) ? {53'd0, 1'b1, h[9:0]} : {54'd0, h[9:0]};
        e = (h[14:10] != 0) ? int'(h[14:10]) - 25 : -24;
    endfunction

    // Round a magnitude in units of 2^-27 to binary16, nearest even
    function automatic logic [15:0] fp16_round(logic sign, longint unsigned mag);
        int h, s;
        longint unsigned q, rem, half, b;
        logic [14:0] bits;
        h = 63;
        while (h > 0 && !mag[h]) h--;
        s = (h - 10 > 3) ? h - 10 : 3;
        q = mag >> s;
        rem = mag & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q++;
        if (s - 3 > 40) begin
            bits = 15'h7C00;
        end else begin
            b = (longint'(s - 3) << 10) + q;
            bits = (b >= 64'h7C00) ? 15'h7C00 : b[14:0];
        end
        return {sign, bits};
    endfunction

    // Fused alpha*x+beta with one rounding
    function automatic logic [15:0] fp16_fma(logic [15:0] a, logic [15:0] x, logic [15:0] b);
        logic sp, sgn;
        bit anan, xnan, bnan, ainf, xinf, binf;
        longint unsigned ma, mx, mb, p, bb, mag, lost;
        int ea, ex, eb, t;
        sp = a[15] ^ x[15];
        anan = a[14:10] == 5'h1F && a[9:0] != 0;
        xnan = x[14:10] == 5'h1F && x[9:0] != 0;
        bnan = b[14:10] == 5'h1F && b[9:0] != 0;
        ainf = a[14:0] == 15'h7C00;
        xinf = x[14:0] == 15'h7C00;
        binf = b[14:0] == 15'h7C00;
        if (anan || xnan || bnan) return FP16_QNAN;
        if (ainf || xinf) begin
            if (a[14:0] == 0 || x[14:0] == 0) return FP16_QNAN;
            if (binf && b[15] != sp) return FP16_QNAN;
            return {sp, 15'h7C00};
        end
        if (binf) return b;
        fp16_split(a, ma, ea);
        fp16_split(x, mx, ex);
        fp16_split(b, mb, eb);
        p = ma * mx;
        t = ea + ex + 27;
        if (t >= 0) begin
            p = p << t;
        end else begin
            lost = p & ((64'd1 << -t) - 1);
            p = p >> -t;
            if (lost != 0) p = p | 64'd1;
        end
        bb = mb << (eb + 27);
        if (sp == b[15]) begin
            mag = p + bb;
            sgn = sp;
        end else if (p >= bb) begin
            mag = p - bb;
            sgn = sp;
        end else begin
            mag = bb - p;
            sgn = b[15];
        end
        if (mag == 0) return (p == 0 && bb == 0) ? {sp & b[15], 15'd0} : 16'h0000;
        return fp16_round(sgn, mag);
    endfunction

    logic i_clk, i_rst_n;
    logic push, full, empty, pop;
    t_in_word i_item;
    t_out_word o_word;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    affine_scoreboard sb;
    int unsigned accepts;
    int unsigned push_calm, pop_calm;

    per_channel_scale_bias_fp16 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_word(o_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length: mostly short, a few long, none inside calm stretches
    function automatic int unsigned gap_len(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 120);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7: return $urandom_range(1, 3);
            8: return $urandom_range(4, 10);
            default: return $urandom_range(11, 40);
        endcase
    endfunction

    // Binary16 operand with a bias toward special encodings
    function automatic logic [15:0] fp16_pick();
        logic s;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 11))
            0: return {s, 15'h0000};
            1: return {s, 15'h7C00};
            2: return {s, 5'h1F, 10'($urandom_range(1, 1023))};
            3: return {s, 5'h00, 10'($urandom_range(1, 1023))};
            4: return {s, 15'h7BFF};
            5: return {s, 5'h0F, 10'($urandom_range(0, 1023))};
            6: return {s, 5'h1E, 10'($urandom_range(0, 1023))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: pop with random stalls, check each word taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                sb.check_word(o_word);
                accepts++;
            end
            pop <= (gap_len(pop_calm) == 0);
        end
    end

    // Watchdog: stop when nothing has moved for too long
    initial begin : watchdog
        int unsigned idle, seen;
        idle = 0;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (accepts != seen) begin
                seen = accepts;
                idle = 0;
            end else if (++idle >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one word after a random gap, hold until taken
    task automatic send_word(t_in_word w);
        int unsigned gap;
        gap = gap_len(push_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_word(w);
        accepts++;
    endtask

    task automatic load_coef(logic [9:0] idx, logic [15:0] a, logic [15:0] b);
        t_in_word w;
        w = t_in_word'(59'({$urandom, $urandom}));
        w.cmd = CMD_LOAD;
        w.coef_index = idx;
        w.alpha_value = a;
        w.beta_value = b;
        send_word(w);
    endtask

    // Send a sample, loading its channel first when the table would be read unwritten
    task automatic send_sample(logic [15:0] x);
        t_in_word w;
        int unsigned ch;
        if (!sb.next_ready(ch)) load_coef(10'(ch), fp16_pick(), fp16_pick());
        w = t_in_word'(59'({$urandom, $urandom}));
        w.cmd = CMD_SAMPLE;
        w.sample = x;
        send_word(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        accepts++;
        i_cfg_valid <= 1'b0;
    endtask

    // Drain outstanding results before touching configuration
    task automatic quiesce();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned phase);
        logic [1:0] lay;
        logic [10:0] cnt;
        logic [23:0] pl;
        lay = 2'($urandom_range(0, 3));
        cnt = 11'($urandom_range(1, 20));
        pl = 24'($urandom_range(1, 6));
        case (phase)
            0: begin lay = LAYOUT_BLOCKED; cnt = 11'd1024; pl = 24'd1; end
            1: begin lay = LAYOUT_PLANAR; cnt = 11'd3; pl = 24'hFFFFFF; end
            2: begin lay = LAYOUT_INTERLEAVED; cnt = 11'd0; pl = 24'd0; end
            3: begin lay = LAYOUT_BLOCKED; cnt = 11'd2047; pl = 24'd1; end
            4: begin lay = LAYOUT_BLOCKED; cnt = 11'd12; pl = 24'd2; end
            5: begin lay = 2'd3; cnt = 11'd5; end
            6: begin lay = LAYOUT_INTERLEAVED; cnt = 11'd1; end
            default: ;
        endcase
        if (lay == LAYOUT_BLOCKED && phase > 4 && $urandom_range(0, 1)) cnt = cnt & ~11'd7 | 11'd8;
        write_reg(CFG_LAYOUT, {22'd0, lay});
        write_reg(CFG_CHANNELS, {13'd0, cnt});
        write_reg(CFG_PLANE, pl);
        write_reg(CFG_USE_ALPHA, phase == 3 ? 24'd0 : 24'($urandom_range(0, 3) != 0));
        write_reg(CFG_USE_BETA, phase == 3 ? 24'd0 : 24'($urandom_range(0, 3) != 0));
        // unmapped indexes leave everything untouched
        if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(5, 7)), 24'($urandom));
    endtask

    initial begin : stimulus
        int unsigned n;
        sb = new();
        accepts = 0;
        push_calm = 0;
        pop_calm = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: special operands on channel zero, extreme table index
        load_coef(10'd1023, 16'hFFFF, 16'h0000);
        load_coef(10'd0, 16'h7C00, 16'hFC00);
        send_sample(16'h3C00);
        send_sample(16'h0000);
        load_coef(10'd0, 16'h8000, 16'h8000);
        send_sample(16'h0000);
        send_sample(16'h8000);
        load_coef(10'd0, 16'h7BFF, 16'h7BFF);
        send_sample(16'h7BFF);
        send_sample(16'hFBFF);
        load_coef(10'd0, 16'h0001, 16'h8001);
        send_sample(16'h0001);
        send_sample(16'h3C00);
        load_coef(10'd0, 16'h7E01, 16'h3C00);
        send_sample(16'h3C00);
        load_coef(10'd0, 16'h3C00, 16'hFC00);
        send_sample(16'h7C00);
        send_sample(16'hFFFF);
        load_coef(10'd0, 16'h3C01, 16'hBC00);
        send_sample(16'h3BFF);
        send_sample(16'h0000);
        quiesce();

        // Random phases under changing configuration
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            configure(ph);
            n = 0;
            while (n < PHASE_WORDS) begin
                if ($urandom_range(0, 6) == 0) begin
                    load_coef($urandom_range(0, 3) == 0 ? 10'($urandom)
                                                        : 10'($urandom_range(0, 23)),
                              fp16_pick(), fp16_pick());
                end else begin
                    send_sample(fp16_pick());
                end
                n++;
            end
            quiesce();
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
